/* design/frp_pkg.sv */
// ----------------------------------------------------------------------------
// frp_pkg
// shared types and register indexes for the request picker
// ----------------------------------------------------------------------------
package frp_pkg;

  localparam int unsigned IDX_W   = 5;
  localparam int unsigned ARR_W   = 32;
  localparam int unsigned CAP_W   = 32;
  localparam int unsigned CFG_A_W = 1;

  // register indexes on the configuration channel
  localparam logic [CFG_A_W-1:0] CFG_ROWHIT_PRIORITY = 1'd0;
  localparam logic [CFG_A_W-1:0] CFG_STARVE_CAP      = 1'd1;

  typedef struct packed {
    logic [IDX_W-1:0] index;
    logic             ready;
    logic             hit;
  } frp_entry_t;

  typedef struct packed {
    logic             rowhit_priority;
    logic [CAP_W-1:0] starve_cap;
  } frp_cfg_t;

endpackage

/* design/frp_compare.sv */
// ----------------------------------------------------------------------------
// frp_compare
// decides whether the held candidate stays ahead of a new queue entry
// ----------------------------------------------------------------------------
module frp_compare #(
  parameter int unsigned TW = 32
) (
  input  frp_pkg::frp_cfg_t   cfg,
  input  frp_pkg::frp_entry_t best,
  input  logic [TW-1:0]       best_arrival,
  input  frp_pkg::frp_entry_t cur,
  input  logic [TW-1:0]       cur_arrival,
  output logic                keep
);
  import frp_pkg::*;

  localparam int unsigned SW = ((TW > CAP_W) ? TW : CAP_W) + 1;

  logic [SW-1:0] best_plus_cap;
  logic [SW-1:0] cur_plus_cap;
  logic          cap_on;
  logic          best_starves;
  logic          cur_starves;

  // one bit wider so the sums never wrap
  assign best_plus_cap = SW'(best_arrival) + SW'(cfg.starve_cap);
  assign cur_plus_cap  = SW'(cur_arrival) + SW'(cfg.starve_cap);
  assign cap_on        = (cfg.starve_cap != '0);
  assign best_starves  = cap_on && (best_plus_cap < SW'(cur_arrival));
  assign cur_starves   = cap_on && (cur_plus_cap < SW'(best_arrival));

  always_comb begin
    priority if (best.ready != cur.ready) begin
      keep = best.ready;
    end else if (cfg.rowhit_priority && best_starves) begin
      keep = 1'b1;
    end else if (cfg.rowhit_priority && cur_starves) begin
      keep = 1'b0;
    end else if (cfg.rowhit_priority && (best.hit != cur.hit)) begin
      keep = best.hit;
    end else begin
      keep = (best_arrival <= cur_arrival);
    end
  end

endmodule

/* design/frfcfs_request_picker.sv */
// ----------------------------------------------------------------------------
// frfcfs_request_picker
// first-ready, first-come-first-served request picker with row-hit tier
// ----------------------------------------------------------------------------
// Takes one pending-queue entry per clock cycle, back to back, and keeps the
// best entry seen so far in the round; the entry marked with tlast closes the
// round; its chosen index passes through the input register and then the result
// register before it leaves on the result channel. The rate is set by the
// combinational compare of each entry against the held best.
// Input stalls only while a finished round waits behind an untaken result.
// Configuration writes are taken every cycle and are meant for idle periods.
module frfcfs_request_picker #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // [4:0] entry_index, [5] is_ready, [6] row_hit, [38:7] arrival_time, [39] zero
  input  logic [39:0]                   in_tdata,
  input  logic                          in_tlast,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // [4:0] chosen_index, [5] chosen_ready, [6] chosen_row_hit, [7] zero
  output logic [7:0]                    out_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  input  logic [frp_pkg::CFG_A_W-1:0]   cfg_index,
  input  logic [frp_pkg::CAP_W-1:0]     cfg_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready
);
  import frp_pkg::*;

  localparam int unsigned TW = (TIME_WIDTH < ARR_W) ? TIME_WIDTH : ARR_W;

  frp_cfg_t   cfg_r;
  logic       v_r;
  frp_entry_t ent_r;
  logic [TW-1:0] arr_r;
  logic       last_r;
  logic       have_r;
  frp_entry_t best_r;
  logic [TW-1:0] best_arr_r;
  logic       out_valid_r;
  frp_entry_t out_r;

  logic       keep;
  logic       take;
  logic       adv;
  logic       out_free;
  logic       in_acc;

  assign cfg_ready  = 1'b1;
  assign out_free   = !out_valid_r || out_tready;
  assign adv        = v_r && (!last_r || out_free);
  assign in_tready  = !v_r || adv;
  assign in_acc     = in_tvalid && in_tready;
  assign take       = !have_r || !keep;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_r.hit, out_r.ready, out_r.index};

  frp_compare #(.TW(TW)) u_cmp (
    .cfg          (cfg_r),
    .best         (best_r),
    .best_arrival (best_arr_r),
    .cur          (ent_r),
    .cur_arrival  (arr_r),
    .keep         (keep)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= '0;
      v_r         <= 1'b0;
      have_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_ROWHIT_PRIORITY: cfg_r.rowhit_priority <= cfg_data[0];
          CFG_STARVE_CAP:      cfg_r.starve_cap      <= cfg_data;
          default: ;
        endcase
      end
      if (in_acc) begin
        v_r <= 1'b1;
      end else if (adv) begin
        v_r <= 1'b0;
      end
      if (adv) begin
        have_r <= !last_r;
      end
      if (adv && last_r) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      ent_r.index <= in_tdata[4:0];
      ent_r.ready <= in_tdata[5];
      ent_r.hit   <= in_tdata[6];
      arr_r       <= in_tdata[7 +: TW];
      last_r      <= in_tlast;
    end
    if (adv && take) begin
      best_r     <= ent_r;
      best_arr_r <= arr_r;
    end
    if (adv && last_r) begin
      out_r <= take ? ent_r : best_r;
    end
  end

  a_stall_only_on_full_result: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (v_r && last_r && out_valid_r && !out_tready))
    else $error("input stalled without a pending result");

  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && last_r) |=> out_valid_r)
    else $error("closed round produced no result");

  a_round_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && last_r) |=> !have_r)
    else $error("candidate survived end of round");

  a_round_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && !last_r) |=> have_r)
    else $error("candidate lost mid round");

endmodule
